@@ hw/rtl/sitpd_pkg.sv @@
// sitpd_pkg: shared constants for the signed integer to padded decimal converter
// field widths, ascii codes and the reciprocal used for the divide by ten
// no dependencies
package sitpd_pkg;

  localparam int VALUE_W      = 32;
  localparam int CHAR_W       = 8;
  localparam int WIDTH_W      = 6;
  localparam int DIGIT_W      = 4;
  localparam int STORE_DEPTH  = 10;
  localparam int CNT_W        = $clog2(STORE_DEPTH);
  localparam int TEXT_W       = 4;
  localparam int PROD_W       = 2 * VALUE_W;

  // saturation limit for the configured width
  localparam logic [WIDTH_W-1:0] MAX_WIDTH     = WIDTH_W'(32);
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = WIDTH_W'(6);

  // floor(n / 10) == (n * 0xCCCCCCCD) >> 35 for every 32-bit n
  localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int                 DIV10_SHIFT = 35;
  localparam int                 QUOT_W      = PROD_W - DIV10_SHIFT;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

endpackage

@@ hw/rtl/signed_int_to_padded_decimal.sv @@
// signed_int_to_padded_decimal: right-justified decimal ascii text of a signed value
// one shared divide-by-ten unit extracts digits, then a character sequencer emits
// depends on sitpd_pkg
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+------------------------------------
//  in_     | in  | in_tvalid / in_tready    | in_tdata[31:0] value (signed)
//  out_    | out | out_tvalid / out_tready  | out_tdata[7:0] char_out, out_tlast last
//  cfg_    | in  | cfg_wr_en                | cfg_wr_data[5:0] min_width
//
// digits are extracted one at a time through the reciprocal multiplier, then
// characters are emitted one at a time, paced by the output register
// in_tready is high only while idle; out_tready low holds the current character
// synchronous active-low reset clears the sequencer and sets min_width to 6
module signed_int_to_padded_decimal (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // cfg_wr_data: min_width
  input  logic                                    cfg_wr_en,
  input  logic [sitpd_pkg::WIDTH_W-1:0]           cfg_wr_data,
  // in_tdata: value
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic signed [sitpd_pkg::VALUE_W-1:0]    in_tdata,
  // out_tdata: char_out
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [sitpd_pkg::CHAR_W-1:0]            out_tdata,
  output logic                                    out_tlast
);

  import sitpd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic [WIDTH_W-1:0]    min_width_r;
  logic [VALUE_W-1:0]    mag_r;
  logic                  neg_r;
  logic                  sign_pend_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [WIDTH_W-1:0]    pad_r;
  logic [DIGIT_W-1:0]    digit_store [STORE_DEPTH];

  logic                  out_tvalid_r;
  logic [CHAR_W-1:0]     out_tdata_r;
  logic                  out_tlast_r;

  logic [PROD_W-1:0]     prod;
  logic [QUOT_W-1:0]     quot;
  logic [DIGIT_W-1:0]    ten_q_lo;
  logic [DIGIT_W-1:0]    digit;
  logic [TEXT_W-1:0]     text_len;
  logic [WIDTH_W-1:0]    width_sat;
  logic [WIDTH_W-1:0]    pad_calc;
  logic                  out_load;

  // shared divide-by-ten unit: quotient by reciprocal, remainder from low bits
  assign prod     = PROD_W'(mag_r) * PROD_W'(DIV10_RECIP);
  assign quot     = prod[PROD_W-1:DIV10_SHIFT];
  assign ten_q_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign digit    = mag_r[DIGIT_W-1:0] - ten_q_lo;

  // padding from the saturated width and the text length
  always_comb begin
    text_len  = TEXT_W'(cnt_r) + TEXT_W'(1) + TEXT_W'(neg_r);
    width_sat = (min_width_r > MAX_WIDTH) ? MAX_WIDTH : min_width_r;
    if (width_sat > WIDTH_W'(text_len)) begin
      pad_calc = width_sat - WIDTH_W'(text_len);
    end else begin
      pad_calc = '0;
    end
  end

  assign out_load  = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);
  assign in_tready = (state_r == ST_IDLE);

  // digit store write
  always_ff @(posedge clk) begin
    if (state_r == ST_CONV) begin
      digit_store[cnt_r] <= digit;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      min_width_r  <= MIN_WIDTH_RST;
      neg_r        <= 1'b0;
      sign_pend_r  <= 1'b0;
      cnt_r        <= '0;
      pad_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_width_r <= cfg_wr_data;
      end
      // output valid: set on a new character, cleared once taken
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            neg_r       <= in_tdata[VALUE_W-1];
            sign_pend_r <= in_tdata[VALUE_W-1];
            mag_r       <= in_tdata[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_tdata))
                                               : VALUE_W'(in_tdata);
            cnt_r       <= '0;
            state_r     <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_r <= VALUE_W'(quot);
          if (quot == '0) begin
            pad_r   <= pad_calc;
            state_r <= ST_EMIT;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            priority if (pad_r != '0) begin
              out_tdata_r <= ASCII_SPACE;
              out_tlast_r <= 1'b0;
              pad_r       <= pad_r - WIDTH_W'(1);
            end else if (sign_pend_r) begin
              out_tdata_r <= ASCII_MINUS;
              out_tlast_r <= 1'b0;
              sign_pend_r <= 1'b0;
            end else begin
              out_tdata_r <= ASCII_ZERO | CHAR_W'(digit_store[cnt_r]);
              out_tlast_r <= (cnt_r == '0);
              if (cnt_r == '0) begin
                state_r <= ST_IDLE;
              end else begin
                cnt_r <= cnt_r - CNT_W'(1);
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef ASSERT_OFF
  // remainder from the divide unit is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (digit < DIGIT_W'(10)))
    else $error("digit out of range");

  // digit pointer stays inside the store
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (cnt_r < CNT_W'(STORE_DEPTH)))
    else $error("digit pointer beyond store");

  // a zero quotient ends the conversion
  a_conv_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) && (quot == '0) |=> (state_r == ST_EMIT))
    else $error("conversion did not end");

  // the final character is always a digit
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      ((out_tdata >= ASCII_ZERO) && (out_tdata <= (ASCII_ZERO + CHAR_W'(9)))))
    else $error("last character is not a digit");
`endif

endmodule
